>>> design/spq_pkg.sv
package spq_pkg;

  localparam int ITEM_W = 32;
  localparam int LVL_W  = 2;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BADLEVEL = 2'd3
  } status_t;

  // Request from the queue engine to the free slot pool, at most one bit set.
  typedef struct packed {
    logic alloc;
    logic put;
  } spq_pool_op_t;

endpackage

>>> design/strict_priority_queue_unit.sv
// A command accepted through start passes the command register, then the
// result register, and its result appears on the ports with out_valid high.
// Throughput: one command per cycle, busy stays low; the head of each level is
// kept in registers and the next head is prefetched from the data and link memories.
// Reset (rst_n low, synchronous) empties every level and returns all slots.
// The receiver cannot stall: each result is shown for exactly one cycle.
module strict_priority_queue_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int LEVELS     = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_func,
  input  logic [spq_pkg::ITEM_W-1:0] in_item_data,
  input  logic [spq_pkg::LVL_W-1:0]  in_priority_level,
  output logic                       out_valid,
  output logic [spq_pkg::ITEM_W-1:0] out_data,
  output spq_pkg::status_t           out_status
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = $clog2(LEVELS);

  // Command register.
  logic              cmd_vld_r;
  logic              cmd_func_r;
  logic [ITEM_W-1:0] cmd_data_r;
  logic [LVL_W-1:0]  cmd_lvl_r;

  // Per-level state: the head word and its link are held here so that a
  // dequeue never waits on a memory read.
  logic [CW-1:0]         cnt_r      [LEVELS];
  logic [CW-1:0]         cnt_nxt    [LEVELS];
  logic [AW-1:0]         hd_slot_r  [LEVELS];
  logic [AW-1:0]         hd_slot_nxt[LEVELS];
  logic [DATA_WIDTH-1:0] hd_data_r  [LEVELS];
  logic [DATA_WIDTH-1:0] hd_data_e  [LEVELS];
  logic [DATA_WIDTH-1:0] hd_data_nxt[LEVELS];
  logic [AW-1:0]         hd_link_r  [LEVELS];
  logic [AW-1:0]         hd_link_e  [LEVELS];
  logic [AW-1:0]         hd_link_nxt[LEVELS];
  logic [AW-1:0]         tail_r     [LEVELS];
  logic [AW-1:0]         tail_nxt   [LEVELS];

  // A refill is pending when last cycle's dequeue fetched the new head.
  logic          pend_r, pend_nxt;
  logic [LW-1:0] pend_lvl_r, pend_lvl_nxt;

  logic              out_valid_r;
  logic [ITEM_W-1:0] out_data_r, out_data_nxt;
  status_t           out_status_r, out_status_nxt;

  logic                  is_enq;
  logic                  bad_lvl;
  logic [LW-1:0]         enq_lv;
  logic [LW-1:0]         deq_lv;
  logic                  any_ne;
  logic [LW-1:0]         lv;
  logic [CW-1:0]         cnt_lv;
  logic                  pool_empty;
  logic [AW-1:0]         free_slot;
  logic                  do_enq;
  logic                  do_deq;
  spq_pool_op_t          pool_op;
  logic [DATA_WIDTH-1:0] data_rd;
  logic [AW-1:0]         link_rd;
  logic [AW-1:0]         rd_addr;
  logic                  link_we;

  assign busy = 1'b0;

  assign is_enq  = (cmd_func_r == FUNC_ENQ);
  assign bad_lvl = (cmd_lvl_r == '0) || (int'(cmd_lvl_r) > LEVELS);
  assign enq_lv  = LW'(cmd_lvl_r - LVL_W'(1));

  always_comb begin
    any_ne = 1'b0;
    deq_lv = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        any_ne = 1'b1;
        deq_lv = LW'(i);
      end
    end
  end

  assign lv     = is_enq ? enq_lv : deq_lv;
  assign cnt_lv = cnt_r[lv];

  assign do_enq = cmd_vld_r && is_enq && !bad_lvl && !pool_empty;
  assign do_deq = cmd_vld_r && !is_enq && any_ne;

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      if (pend_r && (pend_lvl_r == LW'(l))) begin
        hd_data_e[l] = data_rd;
        hd_link_e[l] = link_rd;
      end else begin
        hd_data_e[l] = hd_data_r[l];
        hd_link_e[l] = hd_link_r[l];
      end
    end
  end

  assign pool_op.alloc = do_enq;
  assign pool_op.put   = do_deq;

  spq_free_pool #(
    .DEPTH(DEPTH)
  ) u_pool (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (pool_op),
    .put_slot  (hd_slot_r[lv]),
    .free_slot (free_slot),
    .pool_empty(pool_empty)
  );

  assign rd_addr = hd_link_e[lv];
  assign link_we = do_enq && (cnt_lv != '0);

  spq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_data (
    .clk  (clk),
    .we   (do_enq),
    .waddr(free_slot),
    .wdata(DATA_WIDTH'(cmd_data_r)),
    .raddr(rd_addr),
    .rdata(data_rd)
  );

  spq_ram #(
    .WIDTH(AW),
    .DEPTH(DEPTH)
  ) u_link (
    .clk  (clk),
    .we   (link_we),
    .waddr(tail_r[lv]),
    .wdata(free_slot),
    .raddr(rd_addr),
    .rdata(link_rd)
  );

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      cnt_nxt[l]     = cnt_r[l];
      hd_slot_nxt[l] = hd_slot_r[l];
      hd_data_nxt[l] = hd_data_e[l];
      hd_link_nxt[l] = hd_link_e[l];
      tail_nxt[l]    = tail_r[l];
    end
    pend_nxt     = 1'b0;
    pend_lvl_nxt = lv;

    if (do_enq) begin
      if (cnt_lv == '0) begin
        hd_slot_nxt[lv] = free_slot;
        hd_data_nxt[lv] = DATA_WIDTH'(cmd_data_r);
      end else if (cnt_lv == CW'(1)) begin
        // The tail is also the head, so its new link goes to the register.
        hd_link_nxt[lv] = free_slot;
      end
      tail_nxt[lv] = free_slot;
      cnt_nxt[lv]  = cnt_lv + CW'(1);
    end

    if (do_deq) begin
      if (cnt_lv > CW'(1)) begin
        hd_slot_nxt[lv] = hd_link_e[lv];
        pend_nxt        = 1'b1;
      end
      cnt_nxt[lv] = cnt_lv - CW'(1);
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (is_enq) begin
      priority if (bad_lvl) begin
        out_status_nxt = ST_BADLEVEL;
      end else if (pool_empty) begin
        out_status_nxt = ST_FULL;
      end else begin
        out_status_nxt = ST_OK;
      end
    end else if (any_ne) begin
      out_status_nxt = ST_OK;
      out_data_nxt   = ITEM_W'(hd_data_e[deq_lv]);
    end else begin
      out_status_nxt = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
    end else begin
      cmd_vld_r   <= start && !busy;
      out_valid_r <= cmd_vld_r;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_func_r <= in_func;
      cmd_data_r <= in_item_data;
      cmd_lvl_r  <= in_priority_level;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    pend_lvl_r   <= pend_lvl_nxt;
    hd_slot_r    <= hd_slot_nxt;
    hd_data_r    <= hd_data_nxt;
    hd_link_r    <= hd_link_nxt;
    tail_r       <= tail_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;

endmodule

>>> design/spq_ram.sv
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/spq_free_pool.sv
module spq_free_pool #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spq_pkg::spq_pool_op_t op,
  input  logic [AW-1:0]         put_slot,
  output logic [AW-1:0]         free_slot,
  output logic                  pool_empty
);
  import spq_pkg::*;

  // Slots never handed out yet come from a counter. Returned slots go on a
  // stack whose top lives in top_r and whose next entry is either held in
  // below_r or arrives from the stack memory in the cycle after a pop.
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [AW-1:0] top_r, top_nxt;
  logic [AW-1:0] below_r, below_nxt;
  logic          use_ram_r, use_ram_nxt;

  logic          from_stack;
  logic [AW-1:0] below_eff;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] st_raddr;
  logic [AW-1:0] st_rdata;
  logic [CW-1:0] sp_m1;
  logic [CW-1:0] sp_m3;

  spq_ram #(
    .WIDTH(AW),
    .DEPTH(DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(top_r),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  assign from_stack = (sp_r != '0);
  assign below_eff  = use_ram_r ? st_rdata : below_r;
  assign free_slot  = from_stack ? top_r : fresh_r[AW-1:0];
  assign pool_empty = !from_stack && (fresh_r == CW'(DEPTH));

  assign sp_m1    = sp_r - CW'(1);
  assign sp_m3    = sp_r - CW'(3);
  assign st_we    = op.put && from_stack;
  assign st_waddr = sp_m1[AW-1:0];
  // On a pop the entry just below the new top is fetched for the next pop.
  assign st_raddr = sp_m3[AW-1:0];

  always_comb begin
    top_nxt     = top_r;
    below_nxt   = below_eff;
    sp_nxt      = sp_r;
    fresh_nxt   = fresh_r;
    use_ram_nxt = 1'b0;
    priority if (op.alloc) begin
      if (from_stack) begin
        top_nxt     = below_eff;
        sp_nxt      = sp_m1;
        use_ram_nxt = 1'b1;
      end else begin
        fresh_nxt = fresh_r + CW'(1);
      end
    end else if (op.put) begin
      below_nxt = top_r;
      top_nxt   = put_slot;
      sp_nxt    = sp_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r   <= '0;
      sp_r      <= '0;
      use_ram_r <= 1'b0;
    end else begin
      fresh_r   <= fresh_nxt;
      sp_r      <= sp_nxt;
      use_ram_r <= use_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    below_r <= below_nxt;
  end

endmodule
